// ----- sv/dpf_pkg.sv -----
// shared types and constants for the duplicate packet filter
package dpf_pkg;

  localparam int DEFAULT_CACHE_DEPTH = 16;
  localparam int LEN_W   = 16;
  localparam int COUNT_W = 32;
  localparam int BYTES_W = 48;
  localparam int ID_W    = 224;

  typedef enum logic [2:0] {
    VERDICT_ERROR     = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_UNWANTED  = 3'd2,
    VERDICT_DUPLICATE = 3'd3,
    VERDICT_NEW       = 3'd4
  } verdict_t;

  typedef struct packed {
    logic        receive_error;
    logic [15:0] packet_length;
    logic        wanted;
    logic [63:0] guid_high;
    logic [63:0] guid_low;
    logic [31:0] source_host;
    logic [15:0] source_port;
    logic [31:0] group_id;
    logic [15:0] fragment_id;
  } dpf_in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [31:0] packets_in;
    logic [31:0] duplicates;
    logic [47:0] bytes_in;
  } dpf_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } dpf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reject;
    logic scan_last;
  } dpf_sts_t;

endpackage

// ----- sv/dpf_ram.sv -----
// generic single write port ram with registered read
module dpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/dpf_ctrl.sv -----
// controller state machine: accept, cache scan, result hand-off
module dpf_ctrl import dpf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dpf_sts_t sts,
  output dpf_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    DONE
  } state_t;

  state_t state;

  assign in_ready   = (state == IDLE);
  assign cmd.load   = (state == IDLE) && in_valid;
  assign cmd.scan   = (state == SCAN);
  assign cmd.finish = (state == DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= sts.reject ? DONE : SCAN;
          end
        end
        SCAN: begin
          if (sts.scan_last) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          state <= DONE;
        end
        DONE: begin
          if (cmd.finish) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting result");

  // one transaction at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !in_ready)
    else $error("input taken while an item is in flight");

endmodule

// ----- sv/dpf_dpath.sv -----
// datapath: item register, identity cache, compare, counters, result register
module dpf_dpath import dpf_pkg::*; #(
  parameter int CACHE_DEPTH = DEFAULT_CACHE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data,
  input  dpf_in_t          in_data,
  input  dpf_cmd_t         cmd,
  output dpf_sts_t         sts,
  output dpf_out_t         out_data
);

  localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(CACHE_DEPTH - 1);

  logic [LEN_W-1:0]       min_length;
  logic [ID_W-1:0]        ident;
  logic [LEN_W-1:0]       length;
  logic                   reject;
  verdict_t               reject_code;
  verdict_t               reject_code_next;
  logic                   hit;
  logic [AW-1:0]          scan_idx;
  logic                   rd_pending;
  logic                   rd_entry_valid;
  logic [CACHE_DEPTH-1:0] entry_valid;
  logic [AW-1:0]          head;
  logic [COUNT_W-1:0]     packets;
  logic [COUNT_W-1:0]     dups;
  logic [BYTES_W-1:0]     bytes;
  logic [ID_W-1:0]        rdata;
  logic [ID_W-1:0]        entry;
  logic                   store_new;
  logic                   short_pkt;

  assign short_pkt = in_data.packet_length < min_length;

  // precedence: receive error, then length, then acceptance
  always_comb begin
    reject_code_next = VERDICT_UNWANTED;
    if (in_data.receive_error) begin
      reject_code_next = VERDICT_ERROR;
    end else if (short_pkt) begin
      reject_code_next = VERDICT_SHORT;
    end
  end

  assign sts.reject    = in_data.receive_error || short_pkt || !in_data.wanted;
  assign sts.scan_last = (scan_idx == LAST_IDX);

  // an entry never written reads as all ones, as its valid bit is still clear
  assign entry     = rd_entry_valid ? rdata : {ID_W{1'b1}};
  assign store_new = cmd.finish && !reject && !hit;

  dpf_ram #(
    .WIDTH (ID_W),
    .DEPTH (CACHE_DEPTH)
  ) u_cache (
    .clk   (clk),
    .we    (store_new),
    .waddr (head),
    .wdata (ident),
    .re    (cmd.scan),
    .raddr (scan_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length  <= '0;
      entry_valid <= '0;
      head        <= '0;
      packets     <= '0;
      dups        <= '0;
      bytes       <= '0;
      rd_pending  <= 1'b0;
      hit         <= 1'b0;
      scan_idx    <= '0;
    end else begin
      if (cfg_we) begin
        min_length <= cfg_data;
      end
      rd_pending <= cmd.scan;
      if (cmd.load) begin
        scan_idx <= '0;
        hit      <= 1'b0;
      end else begin
        if (cmd.scan) begin
          scan_idx <= (scan_idx == LAST_IDX) ? '0 : scan_idx + 1'b1;
        end
        if (rd_pending && (entry == ident)) begin
          hit <= 1'b1;
        end
      end
      if (cmd.finish && !reject) begin
        packets <= packets + 1'b1;
        bytes   <= bytes + BYTES_W'(length);
        if (hit) begin
          dups <= dups + 1'b1;
        end
      end
      if (store_new) begin
        entry_valid[head] <= 1'b1;
        head              <= (head == LAST_IDX) ? '0 : head + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_entry_valid <= entry_valid[scan_idx];
    end
    if (cmd.load) begin
      ident       <= {in_data.guid_high, in_data.guid_low, in_data.source_host,
                      in_data.source_port, in_data.group_id, in_data.fragment_id};
      length      <= in_data.packet_length;
      reject      <= sts.reject;
      reject_code <= reject_code_next;
    end
    if (cmd.finish) begin
      if (reject) begin
        out_data.verdict    <= reject_code;
        out_data.packets_in <= packets;
        out_data.duplicates <= dups;
        out_data.bytes_in   <= bytes;
      end else begin
        out_data.verdict    <= hit ? VERDICT_DUPLICATE : VERDICT_NEW;
        out_data.packets_in <= packets + 1'b1;
        out_data.duplicates <= hit ? dups + 1'b1 : dups;
        out_data.bytes_in   <= bytes + BYTES_W'(length);
      end
    end
  end

  // counters and head move only when a result is released
  a_head_still: assert property (@(posedge clk) disable iff (rst)
    !cmd.finish |=> $stable(head) && $stable(packets) && $stable(dups))
    else $error("cache state changed outside result release");

  // a rejected packet leaves the counters alone
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && reject) |=> $stable(packets) && $stable(bytes))
    else $error("rejected packet changed a counter");

endmodule

// ----- sv/duplicate_packet_filter.sv -----
// duplicate packet filter top level
//
// Takes one received packet header per input transaction on in_valid/in_ready
// and returns one verdict with the running counters on out_valid/out_ready.
// A receive error, a packet shorter than min_length (written through
// cfg_we/cfg_data) or an unwanted packet is dropped and leaves all counters
// alone. Any other packet bumps packets_in and bytes_in and is looked up in a
// ring of the CACHE_DEPTH most recent new identities; a match is a duplicate,
// a miss is stored at the head of the ring.
// A rejected packet goes from accept straight to the DONE state for its result.
// A packet that is looked up first passes through SCAN, which reads one cache
// entry per cycle from a single read port until all CACHE_DEPTH entries are
// read, and then through DRAIN, before its result in DONE.
// One packet is in flight at a time; the next is accepted the cycle after the
// previous result is loaded into the output register.
// Reset clears counters, the ring head, min_length and the entry valid bits,
// so every cache entry reads as all ones; no clearing pass is needed.
// When the receiver stalls the result waits in the output register; a new
// packet is still accepted and worked on, and waits for the register to free.
module duplicate_packet_filter import dpf_pkg::*; #(
  parameter int CACHE_DEPTH = DEFAULT_CACHE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  dpf_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dpf_out_t         out_data,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_data
);

  dpf_cmd_t cmd;
  dpf_sts_t sts;

  dpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dpf_dpath #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
